// File: rtl/median_step_edge_locator_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the median step edge locator
// Concurrent checks in simulation; empty bodies in synthesis.
// ----------------------------------------------------------------------------
`ifndef MEDIAN_STEP_EDGE_LOCATOR_DEFINES_SVH
`define MEDIAN_STEP_EDGE_LOCATOR_DEFINES_SVH

`ifndef SYNTHESIS
// invariant that holds at every clock edge out of reset
`define MSEL_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// condition that forces a consequence in the next cycle
`define MSEL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MSEL_ASSERT_ALWAYS(label, clk, rst_n, expr, msg)
`define MSEL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: rtl/msel_pkg.sv
// ----------------------------------------------------------------------------
// msel_pkg
// Widths, reset values and shared types of the median step edge locator.
// ----------------------------------------------------------------------------
`default_nettype none

package msel_pkg;

    localparam int GAP_W           = 12;  // gap sample width
    localparam int WC_W            = 12;  // window_count register width
    localparam int CNT_W           = 13;  // median counter width
    localparam int POS_W           = 13;  // edge position width
    localparam int SCORE_W         = 15;  // edge score width on the port
    localparam int ACC_W           = 16;  // internal score width, covers HALF_WINDOW up to 8
    localparam int HALF_WINDOW_DEF = 3;
    localparam logic [WC_W-1:0] WC_RESET = 12'd7;

    // flags one sort cell shows to its neighbors
    typedef struct packed {
        logic gt;   // stored value above the incoming sample
        logic old;  // this cell holds the oldest sample
        logic dp;   // oldest sample sits in this cell or to its left
    } cell_flags_t;

    // per-median token from the sample stage to the score stage
    typedef struct packed {
        logic             valid;
        logic             score_en;
        logic             emit;
        logic [CNT_W-1:0] pos;
    } med_tok_t;

    // best-so-far result as the score stage offers it
    typedef struct packed {
        logic                    pending;
        logic [POS_W-1:0]        position;
        logic signed [ACC_W-1:0] score;
    } edge_res_t;

endpackage

`default_nettype wire

// File: rtl/msel_gap_if.sv
// ----------------------------------------------------------------------------
// msel_gap_if
// Valid/ready channel carrying one gap length sample per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface msel_gap_if;
    import msel_pkg::*;

    logic             valid;
    logic             ready;
    logic [GAP_W-1:0] gap_length;

    modport source (output valid, output gap_length, input ready);
    modport sink   (input valid, input gap_length, output ready);
endinterface

`default_nettype wire

// File: rtl/msel_edge_if.sv
// ----------------------------------------------------------------------------
// msel_edge_if
// Valid/ready channel carrying one located edge per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface msel_edge_if;
    import msel_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [POS_W-1:0]          edge_position;
    logic signed [SCORE_W-1:0] edge_score;

    modport source (output valid, output edge_position, output edge_score, input ready);
    modport sink   (input valid, input edge_position, input edge_score, output ready);
endinterface

`default_nettype wire

// File: rtl/msel_sort_cell.sv
// ----------------------------------------------------------------------------
// msel_sort_cell
// One slot of the sorted sample window: drop oldest, insert newest per shift.
// ----------------------------------------------------------------------------
`default_nettype none

module msel_sort_cell #(
    parameter int HALF_WINDOW = msel_pkg::HALF_WINDOW_DEF,
    parameter int CELL_INDEX  = 0
) (
    input  wire logic                                         clk,
    input  wire logic                                         rst_n,
    input  wire logic                                         shift,
    input  wire logic [msel_pkg::GAP_W-1:0]                   x,
    input  wire logic [msel_pkg::GAP_W-1:0]                   left_val,
    input  wire logic [$clog2(2*HALF_WINDOW+1)-1:0]           left_age,
    input  wire msel_pkg::cell_flags_t                        left_flags,
    input  wire logic [msel_pkg::GAP_W-1:0]                   right_val,
    input  wire logic [$clog2(2*HALF_WINDOW+1)-1:0]           right_age,
    input  wire msel_pkg::cell_flags_t                        right_flags,
    output logic [msel_pkg::GAP_W-1:0]                        val,
    output logic [$clog2(2*HALF_WINDOW+1)-1:0]                age,
    output msel_pkg::cell_flags_t                             flags
);
    import msel_pkg::*;

    localparam int WIN   = 2 * HALF_WINDOW + 1;
    localparam int AGE_W = $clog2(WIN);

    logic [GAP_W-1:0] val_reg, val_next;
    logic [AGE_W-1:0] age_reg, age_next;
    logic             prev_gt;
    logic [GAP_W-1:0] prev_val;
    logic [AGE_W-1:0] prev_age;

    assign flags.gt  = (val_reg > x);
    assign flags.old = (age_reg == AGE_W'(WIN - 1));
    assign flags.dp  = left_flags.dp | flags.old;
    assign val       = val_reg;
    assign age       = age_reg;

    always_comb
    begin
        // entry just below this slot once the oldest one is removed
        prev_gt  = left_flags.dp ? flags.gt : left_flags.gt;
        prev_val = left_flags.dp ? val_reg  : left_val;
        prev_age = left_flags.dp ? age_reg  : left_age;
        if (!flags.dp)
        begin
            // oldest sits to the right: list unchanged up to here
            if (!flags.gt)
            begin
                val_next = val_reg;
                age_next = age_reg + AGE_W'(1);
            end
            else if (!left_flags.gt)
            begin
                val_next = x;
                age_next = '0;
            end
            else
            begin
                val_next = left_val;
                age_next = left_age + AGE_W'(1);
            end
        end
        else
        begin
            // oldest at or left of here: list closes up from the right
            if (!right_flags.gt)
            begin
                val_next = right_val;
                age_next = right_age + AGE_W'(1);
            end
            else if (!prev_gt)
            begin
                val_next = x;
                age_next = '0;
            end
            else
            begin
                val_next = prev_val;
                age_next = prev_age + AGE_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            val_reg <= '0;
            age_reg <= AGE_W'(CELL_INDEX);
        end
        else if (shift)
        begin
            val_reg <= val_next;
            age_reg <= age_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/msel_score_unit.sv
// ----------------------------------------------------------------------------
// msel_score_unit
// Median history, step score and first-maximum tracking.
// ----------------------------------------------------------------------------
`default_nettype none

module msel_score_unit #(
    parameter int HALF_WINDOW = msel_pkg::HALF_WINDOW_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       advance,
    input  wire msel_pkg::med_tok_t         tok,
    input  wire logic [msel_pkg::GAP_W-1:0] median,
    output msel_pkg::edge_res_t             res
);
    import msel_pkg::*;

    localparam int HIST = 2 * HALF_WINDOW;

    med_tok_t                tok_reg;
    logic [GAP_W-1:0]        hist_reg  [HIST];
    logic [GAP_W-1:0]        hist_next [HIST];
    logic signed [ACC_W-1:0] best_score_reg, best_score_next;
    logic [POS_W-1:0]        best_pos_reg, best_pos_next;
    logic [ACC_W-1:0]        sum_early, sum_late;
    logic signed [ACC_W-1:0] score;

    always_comb
    begin
        for (int i = 0; i < HIST - 1; i++)
        begin
            hist_next[i] = hist_reg[i + 1];
        end
        hist_next[HIST - 1] = median;
    end

    always_comb
    begin
        sum_early = '0;
        sum_late  = '0;
        for (int i = 0; i < HALF_WINDOW; i++)
        begin
            sum_early = sum_early + ACC_W'(hist_next[i]);
            sum_late  = sum_late  + ACC_W'(hist_next[HALF_WINDOW + i]);
        end
        score = signed'(sum_early - sum_late);
    end

    always_comb
    begin
        if (tok_reg.score_en && (score > best_score_reg))
        begin
            best_score_next = score;
            best_pos_next   = POS_W'(tok_reg.pos);
        end
        else
        begin
            best_score_next = best_score_reg;
            best_pos_next   = best_pos_reg;
        end
    end

    assign res.pending  = tok_reg.valid && tok_reg.emit;
    assign res.position = best_pos_next;
    assign res.score    = best_score_next;

    always_ff @(posedge clk)
    begin
        if (advance && tok_reg.valid)
        begin
            hist_reg <= hist_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg        <= '0;
            best_score_reg <= '0;
            best_pos_reg   <= POS_W'(HALF_WINDOW);
        end
        else if (advance)
        begin
            tok_reg <= tok;
            if (tok_reg.valid)
            begin
                if (tok_reg.emit)
                begin
                    best_score_reg <= '0;
                    best_pos_reg   <= POS_W'(HALF_WINDOW);
                end
                else
                begin
                    best_score_reg <= best_score_next;
                    best_pos_reg   <= best_pos_next;
                end
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/median_step_edge_locator.sv
// ----------------------------------------------------------------------------
// median_step_edge_locator
// Sliding median of 2*HALF_WINDOW+1 gap samples with first-maximum step edge.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake        payload
//  samples   in   valid/ready      gap_length[11:0]
//  result    out  valid/ready      edge_position[12:0], edge_score[14:0]
//  cfg       in   cfg_we (no ack)  cfg_wdata[11:0] -> window_count
//
//  One sample per cycle sustained while result is not stalled. A sample
//  transfer updates the sort chain on its edge; the score stage uses the
//  new median in the next cycle; edges reach result via the output register.
//  Reset leaves window_count at 7 and the run empty; no clearing pass.
//  A stall on result backs up into samples only when the score stage holds
//  a finished edge while the output register is still full.
// ----------------------------------------------------------------------------
`default_nettype none
`include "median_step_edge_locator_defines.svh"

module median_step_edge_locator #(
    parameter int HALF_WINDOW = msel_pkg::HALF_WINDOW_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    msel_gap_if.sink                       samples,
    msel_edge_if.source                    result,
    input  wire logic                      cfg_we,
    input  wire logic [msel_pkg::WC_W-1:0] cfg_wdata
);
    import msel_pkg::*;

    localparam int WIN    = 2 * HALF_WINDOW + 1;
    localparam int HIST   = 2 * HALF_WINDOW;
    localparam int AGE_W  = $clog2(WIN);
    localparam int SCNT_W = $clog2(WIN);

    // configuration
    logic [WC_W-1:0]   window_count_reg;
    logic [CNT_W:0]    cnt_eff;

    // sample stage
    logic              advance;
    logic              accept;
    logic [SCNT_W-1:0] samp_cnt_reg, samp_cnt_next;
    logic [CNT_W-1:0]  med_cnt_reg, med_cnt_next;
    logic              samp_full;
    med_tok_t          tok;

    // sort chain
    logic [GAP_W-1:0]  cell_val   [WIN];
    logic [AGE_W-1:0]  cell_age   [WIN];
    cell_flags_t       cell_flags [WIN];
    logic [WIN-1:0]    old_vec;

    // score stage and output register
    edge_res_t                 res;
    logic                      out_valid_reg, out_valid_next;
    logic [POS_W-1:0]          out_pos_reg;
    logic signed [SCORE_W-1:0] out_score_reg;

    // ------------------------------------------------------------------
    // window_count register; short counts act as one full window
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_count_reg <= WC_RESET;
        end
        else if (cfg_we)
        begin
            window_count_reg <= cfg_wdata;
        end
    end

    assign cnt_eff = (window_count_reg < WC_W'(WIN)) ? (CNT_W + 1)'(WIN)
                                                     : (CNT_W + 1)'(window_count_reg);

    // ------------------------------------------------------------------
    // Flow control: everything moves unless a finished edge is blocked
    // by a full output register.
    // ------------------------------------------------------------------
    assign advance       = !res.pending || !out_valid_reg || result.ready;
    assign samples.ready = advance;
    assign accept        = samples.valid && advance;

    // ------------------------------------------------------------------
    // Sample stage: counts the fill of the window and decides, per
    // median, whether it scores and whether it closes the run.
    // ------------------------------------------------------------------
    assign samp_full = (samp_cnt_reg == SCNT_W'(HIST));

    always_comb
    begin
        tok.valid     = accept && samp_full;
        // scores run from the median that fills the history to the one
        // before the last median of the run
        tok.score_en  = (med_cnt_reg >= CNT_W'(HIST - 1))
                        && (({1'b0, med_cnt_reg} + (CNT_W + 1)'(2)) <= cnt_eff);
        tok.emit      = (({1'b0, med_cnt_reg} + (CNT_W + 1)'(1)) >= cnt_eff);
        // edge position is median index minus half window plus one, plus half window
        tok.pos       = med_cnt_reg + CNT_W'(1);
        samp_cnt_next = samp_cnt_reg;
        med_cnt_next  = med_cnt_reg;
        if (accept)
        begin
            if (!samp_full)
            begin
                samp_cnt_next = samp_cnt_reg + SCNT_W'(1);
            end
            else if (tok.emit)
            begin
                samp_cnt_next = '0;
                med_cnt_next  = '0;
            end
            else
            begin
                med_cnt_next = med_cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            samp_cnt_reg <= '0;
            med_cnt_reg  <= '0;
        end
        else
        begin
            samp_cnt_reg <= samp_cnt_next;
            med_cnt_reg  <= med_cnt_next;
        end
    end

    // ------------------------------------------------------------------
    // Sort chain: WIN cells in ascending order. Each transfer removes the
    // oldest entry and inserts the new sample; each cell looks only at its
    // two neighbors. The middle cell holds the median. Stale contents after
    // a run are flushed before the next median is taken.
    // ------------------------------------------------------------------
    genvar gi;
    generate
        for (gi = 0; gi < WIN; gi++)
        begin : g_cell
            logic [GAP_W-1:0] l_val;
            logic [AGE_W-1:0] l_age;
            cell_flags_t      l_flags;
            logic [GAP_W-1:0] r_val;
            logic [AGE_W-1:0] r_age;
            cell_flags_t      r_flags;

            if (gi == 0)
            begin : g_left_edge
                assign l_val   = '0;
                assign l_age   = '0;
                assign l_flags = '{gt: 1'b0, old: 1'b0, dp: 1'b0};
            end
            else
            begin : g_left
                assign l_val   = cell_val[gi - 1];
                assign l_age   = cell_age[gi - 1];
                assign l_flags = cell_flags[gi - 1];
            end

            if (gi == WIN - 1)
            begin : g_right_edge
                assign r_val   = '0;
                assign r_age   = '0;
                assign r_flags = '{gt: 1'b1, old: 1'b0, dp: 1'b1};
            end
            else
            begin : g_right
                assign r_val   = cell_val[gi + 1];
                assign r_age   = cell_age[gi + 1];
                assign r_flags = cell_flags[gi + 1];
            end

            msel_sort_cell #(
                .HALF_WINDOW (HALF_WINDOW),
                .CELL_INDEX  (gi)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .shift       (accept),
                .x           (samples.gap_length),
                .left_val    (l_val),
                .left_age    (l_age),
                .left_flags  (l_flags),
                .right_val   (r_val),
                .right_age   (r_age),
                .right_flags (r_flags),
                .val         (cell_val[gi]),
                .age         (cell_age[gi]),
                .flags       (cell_flags[gi])
            );

            assign old_vec[gi] = cell_flags[gi].old;
        end
    endgenerate

    // ------------------------------------------------------------------
    // Score stage
    // ------------------------------------------------------------------
    msel_score_unit #(
        .HALF_WINDOW (HALF_WINDOW)
    ) u_score (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .tok     (tok),
        .median  (cell_val[HALF_WINDOW]),
        .res     (res)
    );

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance && res.pending)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res.pending)
        begin
            out_pos_reg   <= res.position;
            out_score_reg <= res.score[SCORE_W-1:0];
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.edge_position = out_pos_reg;
    assign result.edge_score    = out_score_reg;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `MSEL_ASSERT_ALWAYS(a_one_oldest, clk, rst_n, $onehot(old_vec),
        "sort chain lost track of the oldest sample")
    `MSEL_ASSERT_ALWAYS(a_medians_need_full_window, clk, rst_n,
        (med_cnt_reg == '0) || samp_full, "median counted before the window filled")
    `MSEL_ASSERT_NEXT(a_edge_lands, clk, rst_n, res.pending && advance, out_valid_reg,
        "finished edge did not reach the output register")

endmodule

`default_nettype wire
